[rtl/itoa_pkg.sv]
`timescale 1ns / 1ps

package itoa_pkg;

	// Field widths fixed by the interface.
	localparam int WORD_W  = 32;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 8;

	// Default depth of the digit store.
	localparam int MAX_DIGITS_DEF = 32;

	// Character and radix constants.
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0]  ALPHA_GAP   = 8'd7;
	localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] DEC_RADIX   = 5'd10;

	// Status of the serial divider as seen by the sequencer.
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] digit;
		logic [WORD_W-1:0]  quot;
	} div_res_t;

	// Digit value to its ASCII character, letters in upper case.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		c = {{(CHAR_W-DIGIT_W){1'b0}}, d} + ASCII_ZERO;
		if (c > ASCII_NINE) begin
			c = c + ALPHA_GAP;
		end
		return c;
	endfunction

endpackage

[rtl/itoa_div.sv]
`timescale 1ns / 1ps

module itoa_div
	import itoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WORD_W-1:0]  dividend,
	input  logic [RADIX_W-1:0] divisor,
	output div_res_t           res
);

	localparam int STEP_W = $clog2(WORD_W);

	logic [WORD_W-1:0]  quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	logic [RADIX_W-1:0] trial;
	logic               fits;
	logic [RADIX_W-1:0] diff;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, quot_q[WORD_W-1]};
	assign fits  = (trial >= divisor);
	assign diff  = trial - divisor;

	// Control of the bit loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[WORD_W-2:0], fits};
			rem_q  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign res.done  = done_q;
	assign res.digit = rem_q;
	assign res.quot  = quot_q;

endmodule

[rtl/integer_to_ascii_radix_top.sv]
`timescale 1ns / 1ps

// Integer to ASCII converter in a base from 2 to 16.
// The input channel takes a word of a 32-bit number and a radix; a radix below
// two is used as two and one above sixteen as sixteen. The output channel
// gives one word per character, most significant digit first, with last_char
// set on the final one. In base ten a negative number is led by a minus sign.
// Each digit comes from a restoring divider that finds one quotient bit per
// cycle; the digits go to a small store and are then sent out one character
// at a time, each read from the store in a fetch state and loaded into the
// output register in a put state.
// in_ready is high only between numbers. The output register decouples the
// receiver: while it stalls, the character held stays put and conversion of
// the following characters waits for the register to free; the next number
// may already be taken while the final character is still waiting.
// Reset clears the sequencer, the divider control and the output valid flag;
// the block is ready for a number in the first cycle after reset.
module integer_to_ascii_radix_top
	import itoa_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WORD_W-1:0]  number,
	input  logic [RADIX_W-1:0] radix,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  char_out,
	output logic               last_char
);

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W = $clog2(MAX_DIGITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SIGN  = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic               neg_q;
	logic               start_q;
	logic [WORD_W-1:0]  val_q;
	logic [RADIX_W-1:0] radix_q;
	logic               ovalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [DIGIT_W-1:0] rd_q;
	logic [DIGIT_W-1:0] store_q [MAX_DIGITS];

	div_res_t           div_res;
	logic [RADIX_W-1:0] radix_cl;
	logic               neg_in;
	logic [WORD_W-1:0]  mag_in;
	logic [CNT_W-1:0]   count_inc;
	logic [CNT_W-1:0]   count_dec;
	logic               slot_free;
	logic               take_in;

	// Clamp the radix and take the sign apart for base ten.
	always_comb begin
		radix_cl = radix;
		if (radix < RADIX_MIN) begin
			radix_cl = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			radix_cl = RADIX_MAX;
		end
	end

	assign neg_in    = (radix_cl == DEC_RADIX) && number[WORD_W-1];
	assign mag_in    = neg_in ? (WORD_W'(0) - number) : number;
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign slot_free = !ovalid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign take_in   = in_valid && in_ready;

	itoa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (val_q),
		.divisor  (radix_q),
		.res      (div_res)
	);

	// Sequencer: divide down, then send the sign and the stored digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			neg_q    <= 1'b0;
			start_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						neg_q   <= neg_in;
						count_q <= '0;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						count_q <= count_inc;
						if ((div_res.quot != '0) && (count_inc < CNT_W'(MAX_DIGITS))) begin
							start_q <= 1'b1;
						end else begin
							state_q <= ST_SIGN;
						end
					end
				end
				ST_SIGN: begin
					if (!neg_q) begin
						state_q <= ST_FETCH;
					end else if (slot_free) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						count_q  <= count_dec;
						state_q  <= (count_q == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: working value, radix and the output character.
	always_ff @(posedge clk) begin
		if (take_in) begin
			val_q   <= mag_in;
			radix_q <= radix_cl;
		end else if ((state_q == ST_DIV) && div_res.done) begin
			val_q <= div_res.quot;
		end
		if ((state_q == ST_SIGN) && neg_q && slot_free) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if ((state_q == ST_PUT) && slot_free) begin
			char_q <= digit_char(rd_q);
			last_q <= (count_q == CNT_W'(1));
		end
	end

	// Digit store, least significant digit at entry zero.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && div_res.done) begin
			store_q[count_q[IDX_W-1:0]] <= div_res.digit;
		end
		if (state_q == ST_FETCH) begin
			rd_q <= store_q[count_dec[IDX_W-1:0]];
		end
	end

	assign out_valid = ovalid_q;
	assign char_out  = char_q;
	assign last_char = last_q;

	// The digit count never passes the depth of the store.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond store depth");

	// A character is only fetched while digits remain.
	a_put_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_PUT) |-> (count_q != '0))
		else $error("character fetch with empty store");

	// The divider only reports while the sequencer waits for it.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider done outside the divide state");

	// Loading the final character returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && slot_free && count_q == CNT_W'(1)) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after final character");

	// A minus sign is only given in base ten and is never the final character.
	a_minus_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && char_q == ASCII_MINUS) |-> (radix_q == DEC_RADIX && !last_q))
		else $error("minus sign outside base ten");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import itoa_pkg::*;

	localparam int  LIMIT_CYCLES = 4_000_000;
	localparam int  RANDOM_NUMBERS = 260;
	localparam int  TAIL_CYCLES = 80;
	localparam logic [CHAR_W-1:0] LETTER_A = 8'd65;

	// One number waiting to be sent, with the idle time that follows it.
	typedef struct {
		logic [WORD_W-1:0]  value;
		logic [RADIX_W-1:0] base;
		int                 gap;
		bit                 drain;
	} number_req_t;

	// One character that the converter is expected to emit.
	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic              last;
	} char_exp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [WORD_W-1:0]  number = '0;
	logic [RADIX_W-1:0] radix = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [CHAR_W-1:0]  char_out;
	logic               last_char;

	number_req_t pending_numbers[$];
	char_exp_t   expected_chars[$];
	number_req_t tx_cur;
	char_exp_t   rx_want;
	int          tx_gap = 0;
	int          rx_gap = 0;
	logic        tx_hold;
	logic        tx_next;
	int          numbers_queued = 0;
	int          numbers_sent = 0;
	int          chars_seen = 0;
	int          neg_decimals = 0;
	int          clamped_radix = 0;
	int          longest_digits = 0;
	int          error_count = 0;
	longint      cycle_count = 0;

	integer_to_ascii_radix_top #(
		.MAX_DIGITS(MAX_DIGITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.radix(radix),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.last_char(last_char)
	);

	always #10 clk = ~clk;

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 0;
		end else if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Works out the characters of one number and queues them as expectations.
	task automatic predict_chars(input logic [WORD_W-1:0] value, input logic [RADIX_W-1:0] base_in);
		logic [RADIX_W-1:0] base;
		logic [WORD_W-1:0]  mag;
		logic [DIGIT_W-1:0] digs[$];
		logic [DIGIT_W-1:0] d;
		logic               neg;
		char_exp_t          c;
		base = base_in;
		if (base_in < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (base_in > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		if (base != base_in) begin
			clamped_radix++;
		end
		neg = (base == DEC_RADIX) && value[WORD_W-1];
		mag = neg ? (~value + 1'b1) : value;
		do begin
			digs.push_front(DIGIT_W'(mag % base));
			mag = mag / base;
		end while (mag != 0 && digs.size() < MAX_DIGITS_DEF);
		if (digs.size() > longest_digits) begin
			longest_digits = digs.size();
		end
		if (neg) begin
			neg_decimals++;
			c.glyph = ASCII_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int i = 0; i < digs.size(); i++) begin
			d = digs[i];
			c.glyph = (d < 10) ? ASCII_ZERO + CHAR_W'(d) : LETTER_A + CHAR_W'(d) - 8'd10;
			c.last = (i == digs.size() - 1);
			expected_chars.push_back(c);
		end
	endtask

	task automatic queue_number(input logic [WORD_W-1:0] value, input logic [RADIX_W-1:0] base,
			input int gap, input bit drain);
		number_req_t r;
		r.value = value;
		r.base = base;
		r.gap = gap;
		r.drain = drain;
		pending_numbers.push_back(r);
		numbers_queued++;
	endtask

	// Random value: full range, small values of either sign, extremes, powers of the base and right-shifted words.
	function automatic logic [WORD_W-1:0] pick_value(input logic [RADIX_W-1:0] base);
		int               r;
		longint unsigned  p;
		int               b;
		r = $urandom_range(0, 99);
		b = (base < RADIX_MIN) ? 2 : (base > RADIX_MAX) ? 16 : base;
		if (r < 40) begin
			return $urandom();
		end else if (r < 65) begin
			return $urandom_range(0, 999);
		end else if (r < 75) begin
			return -$urandom_range(0, 999);
		end else if (r < 85) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				3: return 32'h8000_0000;
				default: return 32'h8000_0001;
			endcase
		end else if (r < 93) begin
			p = 1;
			repeat ($urandom_range(1, 31)) begin
				if (p * b < 64'h1_0000_0000) begin
					p = p * b;
				end
			end
			return $urandom_range(0, 1) ? WORD_W'(p) : WORD_W'(p - 1);
		end
		return $urandom() >> $urandom_range(1, 31);
	endfunction

	// Reset, then the directed numbers, then the random ones.
	initial begin
		logic [RADIX_W-1:0] b;
		int                 gap;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		queue_number(32'd0, DEC_RADIX, 0, 1'b0);
		queue_number(32'd0, RADIX_MIN, 0, 1'b0);
		queue_number(32'hFFFF_FFFF, DEC_RADIX, 0, 1'b0);
		queue_number(32'h8000_0000, DEC_RADIX, 0, 1'b0);
		queue_number(32'h7FFF_FFFF, DEC_RADIX, 2, 1'b0);
		queue_number(32'h8000_0000, RADIX_MAX, 0, 1'b0);
		queue_number(32'hFFFF_FFFF, RADIX_MIN, 0, 1'b0);
		queue_number(32'h8000_0000, RADIX_MIN, 0, 1'b0);
		queue_number(32'hFFFF_FFFF, RADIX_MAX, 5, 1'b0);
		queue_number(32'd255, RADIX_MAX, 0, 1'b0);
		queue_number(32'h00AB_CDEF, RADIX_MAX, 0, 1'b0);
		queue_number(32'd10, 5'd11, 0, 1'b0);
		queue_number(32'd15, RADIX_MAX, 0, 1'b0);
		queue_number(32'd16, RADIX_MAX, 0, 1'b1);
		queue_number(32'd9, DEC_RADIX, 0, 1'b0);
		queue_number(-32'd1234567890, DEC_RADIX, 0, 1'b0);
		queue_number(-32'd5, 5'd8, 0, 1'b0);
		queue_number(32'd12345, 5'd3, 0, 1'b0);
		queue_number(32'd6, 5'd0, 0, 1'b0);
		queue_number(32'd6, 5'd1, 0, 1'b0);
		queue_number(32'd1000, 5'd17, 0, 1'b0);
		queue_number(32'hDEAD_BEEF, 5'd31, 3, 1'b0);
		queue_number(32'h1234_5678, 5'd7, 0, 1'b0);
		queue_number(-32'd1, 5'd13, 0, 1'b0);

		// Random numbers in blocks, every third block with no idle time.
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				b = $urandom_range(0, 31);
			end else begin
				b = $urandom_range(RADIX_MIN, RADIX_MAX);
			end
			gap = ((i / 40) % 3 == 1) ? 0 : pick_gap();
			queue_number(pick_value(b), b, gap, (i % 50) == 25);
		end

		wait (numbers_sent == numbers_queued);
		wait (expected_chars.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d numbers into %0d characters, %0d negative in base ten,",
			numbers_sent, chars_seen, neg_decimals);
		$display("%0d with an out-of-range base; longest number %0d digits.",
			clamped_radix, longest_digits);
		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Sender: presents one number per word, idles between them as asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			tx_hold = in_valid;
			if (in_valid && in_ready) begin
				predict_chars(number, radix);
				numbers_sent++;
				tx_hold = 1'b0;
			end
			if (!tx_hold) begin
				tx_next = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_numbers.size() != 0 &&
						!(pending_numbers[0].drain && expected_chars.size() != 0)) begin
					tx_cur = pending_numbers.pop_front();
					number <= tx_cur.value;
					radix <= tx_cur.base;
					tx_gap = tx_cur.gap;
					tx_next = 1'b1;
				end
				in_valid <= tx_next;
			end
		end
	end

	// Receiver: checks each character word and stalls now and then.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					error_count++;
					$display("%0t: char_out expected none actual 0x%02h last %0b", $time,
						char_out, last_char);
				end else begin
					rx_want = expected_chars.pop_front();
					if (char_out !== rx_want.glyph) begin
						error_count++;
						$display("%0t: char_out expected 0x%02h actual 0x%02h", $time,
							rx_want.glyph, char_out);
					end
					if (last_char !== rx_want.last) begin
						error_count++;
						$display("%0t: last_char expected %0b actual %0b", $time,
							rx_want.last, last_char);
					end
				end
				if ((chars_seen / 64) % 3 != 2 && $urandom_range(0, 2) == 0) begin
					rx_gap = pick_gap();
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d characters outstanding.",
				cycle_count, expected_chars.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
